@@ rtl/core/sprnn_pkg.sv @@
// Shared types and constants for the sparse recurrent neuron net core.
package sprnn_pkg;

   localparam int MAX_NEURONS_DEF = 64;
   localparam int MAX_SENSORS_DEF = 64;
   localparam int MAX_FAN_IN_DEF  = 16;

   localparam int VAL_W    = 16;
   localparam int IDX_W    = 6;
   localparam int COUNT_W  = 7;
   localparam int CSR_IX_W = 2;
   localparam int Q_FRAC   = 14;

   typedef enum logic [2:0] {
      OP_CLEAR = 3'd0,
      OP_ADD   = 3'd1,
      OP_SET   = 3'd2,
      OP_TICK  = 3'd3,
      OP_READ  = 3'd4
   } op_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_code_type;

   typedef enum logic [CSR_IX_W-1:0] {
      CSR_NEURON_COUNT = 2'd0,
      CSR_OUT_MIN      = 2'd1,
      CSR_OUT_MAX      = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OP,
      S_NCNT,
      S_LINK,
      S_DRAIN,
      S_PREP,
      S_DIV,
      S_WB
   } state_type;

   typedef struct packed {
      logic [2:0]              req_type;
      logic [IDX_W-1:0]        target_index;
      logic                    source_is_sensor;
      logic [IDX_W-1:0]        source_index;
      logic signed [VAL_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] out_value;
      logic [1:0]              status;
   } rsp_item_type;

   typedef struct packed {
      logic                    is_sensor;
      logic [IDX_W-1:0]        src;
      logic signed [VAL_W-1:0] weight;
   } link_entry_type;

endpackage

@@ rtl/core/sprnn_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module sprnn_div #(
   parameter int DW = 24,
   parameter int NW = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [NW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [NW:0]   shifted;
   logic [NW+1:0] diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CW'(DW);
      end else if (cnt_ff != '0) begin
         if (!diff[NW+1]) begin
            rem_in = diff[NW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[NW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/sparse_recurrent_neuron_net_core.sv @@
// Top level: request sequencer, state memories and link MAC pipeline.
// Clear, add, set, read and unknown beats pass through S_OP; busy until the rsp strobe.
// Tick: each neuron with links does one link-memory read per cycle, drains the MAC
//   pipeline and runs the bit-serial divide; a neuron with no links is written to zero.
// One request at a time; rsp_valid pulses one cycle, the receiver cannot stall.
// Synchronous active-high reset clears control state and all valid bits and loads the CSR defaults.
module sparse_recurrent_neuron_net_core #(
   parameter int MAX_NEURONS = sprnn_pkg::MAX_NEURONS_DEF,
   parameter int MAX_SENSORS = sprnn_pkg::MAX_SENSORS_DEF,
   parameter int MAX_FAN_IN  = sprnn_pkg::MAX_FAN_IN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  sprnn_pkg::req_item_type          req_item,
   output logic                             rsp_valid,
   output sprnn_pkg::rsp_item_type          rsp_item,
   input  logic                             csr_we,
   input  logic [sprnn_pkg::CSR_IX_W-1:0]   csr_index,
   input  logic [sprnn_pkg::VAL_W-1:0]      csr_wdata
);

   localparam int VW   = sprnn_pkg::VAL_W;
   localparam int NIW  = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
   localparam int SIW  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
   localparam int FCW  = $clog2(MAX_FAN_IN + 1);
   localparam int KW   = (MAX_FAN_IN > 1) ? $clog2(MAX_FAN_IN) : 1;
   localparam int LDEP = MAX_NEURONS * MAX_FAN_IN;
   localparam int LW   = (LDEP > 1) ? $clog2(LDEP) : 1;
   localparam int CNTW = ($clog2(MAX_NEURONS + 1) > sprnn_pkg::COUNT_W)
                         ? $clog2(MAX_NEURONS + 1) : sprnn_pkg::COUNT_W;
   localparam int PW   = 2 * VW;
   localparam int AW   = PW + KW + 1;
   localparam int NUMW = AW + 3;
   localparam int SH   = sprnn_pkg::Q_FRAC + 2;
   localparam int DW   = NUMW - SH;

   sprnn_pkg::state_type state_ff, state_in;
   sprnn_pkg::req_item_type req_ff, req_in;
   sprnn_pkg::rsp_item_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [sprnn_pkg::COUNT_W-1:0] neuron_count_ff;
   logic signed [VW-1:0] out_min_ff, out_max_ff;

   // memories
   logic signed [VW-1:0]      nv_mem [MAX_NEURONS];
   logic signed [VW-1:0]      sv_mem [MAX_SENSORS];
   logic [FCW-1:0]            fc_mem [MAX_NEURONS];
   sprnn_pkg::link_entry_type lk_mem [LDEP];
   logic [MAX_NEURONS-1:0] nv_vld_ff, fc_vld_ff;
   logic [MAX_SENSORS-1:0] sv_vld_ff;

   logic [NIW-1:0] nv_raddr, fc_raddr, nv_waddr, fc_waddr;
   logic [SIW-1:0] sv_raddr, sv_waddr;
   logic [LW-1:0]  lk_raddr, lk_waddr;
   logic nv_we, sv_we, fc_we, lk_we, clr;
   logic signed [VW-1:0] nv_wdata, sv_wdata;
   logic [FCW-1:0] fc_wdata;
   sprnn_pkg::link_entry_type lk_wdata;
   logic signed [VW-1:0] nv_rd_ff, sv_rd_ff;
   logic [FCW-1:0] fc_rd_ff;
   sprnn_pkg::link_entry_type lk_rd_ff;

   // tick datapath
   logic [NIW-1:0] i_ff, i_in;
   logic [FCW-1:0] n_ff, n_in;
   logic [FCW-1:0] k_ff, k_in;
   logic p1_ff, p2_ff, p3_ff;
   logic sens_ff;
   logic signed [VW-1:0] w_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [AW-1:0] acc_ff;
   logic acc_clr;

   logic [CNTW-1:0] cnt;
   logic [CNTW-1:0] tgt_c, src_c;
   logic signed [NUMW-1:0] num;
   logic [NUMW-1:0] mag;
   logic neg_ff, neg_in;
   logic div_start, div_done;
   logic [DW-1:0] div_quo;
   logic signed [DW:0] q;
   logic signed [DW:0] lo, hi, qc;
   logic [LW-1:0] base_addr;

   assign cnt   = (CNTW'(neuron_count_ff) > CNTW'(MAX_NEURONS))
                  ? CNTW'(MAX_NEURONS) : CNTW'(neuron_count_ff);
   assign tgt_c = CNTW'(req_ff.target_index);
   assign src_c = CNTW'(req_ff.source_index);
   assign base_addr = LW'(LW'(i_ff) * LW'(MAX_FAN_IN));

   assign num = ($signed({acc_ff, 2'b00}) + NUMW'(acc_ff));
   assign mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
   assign q   = neg_ff ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
   assign lo  = (DW+1)'(out_min_ff);
   assign hi  = (DW+1)'(out_max_ff);
   always_comb begin
      qc = (q < lo) ? lo : q;
      qc = (qc > hi) ? hi : qc;
   end

   sprnn_div #(.DW(DW), .NW(FCW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag[NUMW-1:SH]),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      i_in         = i_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      neg_in       = neg_ff;
      acc_clr      = 1'b0;
      div_start    = 1'b0;
      clr          = 1'b0;
      nv_we = 1'b0; sv_we = 1'b0; fc_we = 1'b0; lk_we = 1'b0;
      nv_waddr = i_ff;
      nv_wdata = VW'(qc);
      sv_waddr = SIW'(req_ff.target_index);
      sv_wdata = req_ff.value;
      fc_waddr = NIW'(req_ff.target_index);
      fc_wdata = fc_rd_ff + 1'b1;
      lk_waddr = LW'(LW'(NIW'(req_ff.target_index)) * LW'(MAX_FAN_IN) + LW'(fc_rd_ff));
      lk_wdata = '{is_sensor: req_ff.source_is_sensor, src: req_ff.source_index,
                   weight: req_ff.value};
      nv_raddr = NIW'(lk_rd_ff.src);
      sv_raddr = SIW'(lk_rd_ff.src);
      fc_raddr = NIW'(req_item.target_index);
      lk_raddr = base_addr + LW'(k_ff);
      case (state_ff)
         sprnn_pkg::S_IDLE: begin
            nv_raddr = NIW'(cnt - CNTW'(1) - CNTW'(req_item.target_index));
            if (start) begin
               req_in   = req_item;
               state_in = sprnn_pkg::S_OP;
            end
         end
         sprnn_pkg::S_OP: begin
            rsp_in = '{out_value: '0, status: sprnn_pkg::ST_OK};
            state_in     = sprnn_pkg::S_IDLE;
            rsp_valid_in = 1'b1;
            case (req_ff.req_type)
               sprnn_pkg::OP_CLEAR: clr = 1'b1;
               sprnn_pkg::OP_ADD: begin
                  if (tgt_c >= cnt || (req_ff.source_is_sensor
                        ? (32'(req_ff.source_index) >= MAX_SENSORS) : (src_c >= cnt)))
                     rsp_in.status = sprnn_pkg::ST_RANGE;
                  else if (32'(fc_rd_ff) >= MAX_FAN_IN)
                     rsp_in.status = sprnn_pkg::ST_FULL;
                  else begin
                     lk_we = 1'b1;
                     fc_we = 1'b1;
                  end
               end
               sprnn_pkg::OP_SET: begin
                  if (32'(req_ff.target_index) >= MAX_SENSORS)
                     rsp_in.status = sprnn_pkg::ST_RANGE;
                  else
                     sv_we = 1'b1;
               end
               sprnn_pkg::OP_READ: begin
                  if (tgt_c >= cnt)
                     rsp_in.status = sprnn_pkg::ST_RANGE;
                  else
                     rsp_in.out_value = nv_rd_ff;
               end
               sprnn_pkg::OP_TICK: begin
                  i_in = '0;
                  fc_raddr = '0;
                  if (cnt != '0) begin
                     rsp_valid_in = 1'b0;
                     state_in     = sprnn_pkg::S_NCNT;
                  end
               end
               default: rsp_in.status = sprnn_pkg::ST_RANGE;
            endcase
         end
         sprnn_pkg::S_NCNT: begin
            acc_clr = 1'b1;
            k_in    = '0;
            n_in    = (32'(fc_rd_ff) > MAX_FAN_IN) ? FCW'(MAX_FAN_IN) : fc_rd_ff;
            if (fc_rd_ff == '0) begin
               nv_we    = 1'b1;
               nv_wdata = '0;
               state_in = sprnn_pkg::S_WB;
            end else begin
               state_in = sprnn_pkg::S_LINK;
            end
         end
         sprnn_pkg::S_LINK: begin
            k_in = k_ff + 1'b1;
            if (k_ff + 1'b1 == n_ff)
               state_in = sprnn_pkg::S_DRAIN;
         end
         sprnn_pkg::S_DRAIN: begin
            if (!p1_ff && !p2_ff && !p3_ff)
               state_in = sprnn_pkg::S_PREP;
         end
         sprnn_pkg::S_PREP: begin
            div_start = 1'b1;
            neg_in    = num[NUMW-1];
            state_in  = sprnn_pkg::S_DIV;
         end
         sprnn_pkg::S_DIV: begin
            if (div_done) begin
               nv_we    = 1'b1;
               state_in = sprnn_pkg::S_WB;
            end
         end
         sprnn_pkg::S_WB: begin
            fc_raddr = i_ff + 1'b1;
            if (CNTW'(i_ff) + CNTW'(1) == cnt) begin
               rsp_in       = '{out_value: '0, status: sprnn_pkg::ST_OK};
               rsp_valid_in = 1'b1;
               state_in     = sprnn_pkg::S_IDLE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = sprnn_pkg::S_NCNT;
            end
         end
         default: state_in = sprnn_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= sprnn_pkg::S_IDLE;
         rsp_valid_ff    <= 1'b0;
         neuron_count_ff <= '0;
         out_min_ff      <= -16'sd16384;
         out_max_ff      <= 16'sd16384;
         nv_vld_ff       <= '0;
         sv_vld_ff       <= '0;
         fc_vld_ff       <= '0;
         p1_ff           <= 1'b0;
         p2_ff           <= 1'b0;
         p3_ff           <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_ff        <= (state_ff == sprnn_pkg::S_LINK);
         p2_ff        <= p1_ff;
         p3_ff        <= p2_ff;
         if (csr_we) begin
            case (csr_index)
               sprnn_pkg::CSR_NEURON_COUNT:
                  neuron_count_ff <= csr_wdata[sprnn_pkg::COUNT_W-1:0];
               sprnn_pkg::CSR_OUT_MIN: out_min_ff <= csr_wdata;
               sprnn_pkg::CSR_OUT_MAX: out_max_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (clr) begin
            nv_vld_ff <= '0;
            sv_vld_ff <= '0;
            fc_vld_ff <= '0;
         end else begin
            if (nv_we) nv_vld_ff[nv_waddr] <= 1'b1;
            if (sv_we) sv_vld_ff[sv_waddr] <= 1'b1;
            if (fc_we) fc_vld_ff[fc_waddr] <= 1'b1;
         end
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      i_ff   <= i_in;
      n_ff   <= n_in;
      k_ff   <= k_in;
      neg_ff <= neg_in;
      if (p1_ff) begin
         sens_ff <= lk_rd_ff.is_sensor;
         w_ff    <= lk_rd_ff.weight;
      end
      if (p2_ff)
         prod_ff <= (sens_ff ? sv_rd_ff : nv_rd_ff) * w_ff;
      if (acc_clr)
         acc_ff <= '0;
      else if (p3_ff)
         acc_ff <= acc_ff + AW'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (nv_we) nv_mem[nv_waddr] <= nv_wdata;
      if (sv_we) sv_mem[sv_waddr] <= sv_wdata;
      if (fc_we) fc_mem[fc_waddr] <= fc_wdata;
      if (lk_we) lk_mem[lk_waddr] <= lk_wdata;
      nv_rd_ff <= nv_vld_ff[nv_raddr] ? nv_mem[nv_raddr] : '0;
      sv_rd_ff <= sv_vld_ff[sv_raddr] ? sv_mem[sv_raddr] : '0;
      fc_rd_ff <= fc_vld_ff[fc_raddr] ? fc_mem[fc_raddr] : '0;
      lk_rd_ff <= lk_mem[lk_raddr];
   end

   assign busy      = (state_ff != sprnn_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("rsp strobe longer than one cycle");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("rsp while busy");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
   a_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sprnn_pkg::S_PREP) |-> (!p1_ff && !p2_ff && !p3_ff))
      else $error("divide started with MAC pipeline busy");
`endif

endmodule
